/* rtl/tte_pkg.sv */
`default_nettype none
package tte_pkg;
   localparam int LEAVES = 64;
   localparam int LVL = (LEAVES <= 2) ? 1 : $clog2(LEAVES);
   localparam int PAD = 1 << LVL;
   localparam int NW = LVL + 1;
   localparam int EW = 46;
   localparam int VW = 64;
   localparam logic [EW-1:0] E_MAX = {EW{1'b1}};
   localparam logic signed [VW-1:0] SENT = {1'b1, {(VW-1){1'b0}}};
   localparam logic signed [VW-1:0] ENV_MAX = {2'b00, {(VW-2){1'b1}}};

   typedef enum logic [1:0] {
      REQ_INSERT = 2'd0,
      REQ_REMOVE = 2'd1,
      REQ_CLEAR  = 2'd2,
      REQ_NONE   = 2'd3
   } op_type;

   typedef struct packed {
      op_type          op;
      logic [LVL-1:0]  leaf;
      logic [39:0]     energy;
      logic [62:0]     envelope;
   } cmd_type;
endpackage
`default_nettype wire

/* rtl/tte_front.sv */
`default_nettype none
module tte_front import tte_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_type,
   input  wire logic [5:0]  req_leaf,
   input  wire logic [39:0] req_task_energy,
   input  wire logic [62:0] req_task_envelope,
   output logic             q_valid,
   output cmd_type          q_cmd,
   input  wire logic        q_take
);
   // Two-entry queue; out-of-range or unknown requests become no-ops here.
   cmd_type  mem_ff [2];
   logic [1:0] cnt_ff;
   logic     wp_ff, rp_ff;
   cmd_type  c;
   logic     push;

   always_comb begin
      c.leaf = req_leaf[LVL-1:0];
      c.energy = req_task_energy;
      c.envelope = req_task_envelope;
      if (req_type == 2'(REQ_CLEAR)) c.op = REQ_CLEAR;
      else if (req_type == 2'(REQ_NONE) || 32'(req_leaf) >= LEAVES) c.op = REQ_NONE;
      else c.op = op_type'(req_type);
   end

   assign req_stall = (cnt_ff == 2'd2);
   assign push = req_valid && !req_stall;
   assign q_valid = (cnt_ff != 2'd0);
   assign q_cmd = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= c;
      if (reset) begin
         cnt_ff <= '0; wp_ff <= 1'b0; rp_ff <= 1'b0;
      end else begin
         if (push) wp_ff <= !wp_ff;
         if (q_take) rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(q_take);
      end
   end
endmodule
`default_nettype wire

/* rtl/tte_back.sv */
`default_nettype none
module tte_back import tte_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        q_valid,
   input  wire cmd_type     q_cmd,
   output logic             q_take,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [45:0]      rsp_root_energy,
   output logic [62:0]      rsp_root_envelope,
   output logic [5:0]       rsp_leftmost_leaf,
   output logic             rsp_tree_empty
);
   typedef enum logic [2:0] {S_IDLE, S_LEAF, S_UP, S_DOWN, S_OUT} st_type;
   localparam int NN = 2 * PAD;

   // Node memories with per-node valid bits; an invalid node reads as cleared.
   logic [EW-1:0]        en_mem [NN];
   logic signed [VW-1:0] ev_mem [NN];
   logic [NN-1:0]        vld_ff;

   st_type               st_ff;
   cmd_type              cmd_ff;
   logic [NW-1:0]        n_ff;
   logic [EW-1:0]        cur_e_ff;
   logic signed [VW-1:0] cur_v_ff;
   logic [NW-1:0]        dn_ff;
   logic signed [VW-1:0] dv_ff;
   logic [EW-1:0]        root_e_ff;
   logic signed [VW-1:0] root_v_ff;
   logic [5:0]           lf_ff;

   // Registered read data: port A reads energy and envelope, port B envelope only.
   logic [EW-1:0]        rda_e_ff;
   logic signed [VW-1:0] rda_v_ff;
   logic signed [VW-1:0] rdb_v_ff;
   logic                 rda_vld_ff, rdb_vld_ff;

   logic [NW-1:0]        leaf_n, par_n, nxt_n, addr_a, addr_b, wr_addr;
   logic [EW-1:0]        leaf_e, sib_e, l_e, r_e, pe, wr_e;
   logic signed [VW-1:0] leaf_v, sib_v, rgt_v, l_v, r_v, pa, pv, nxt_v, wr_v;
   logic [EW:0]          esum;
   logic signed [VW:0]   asum;
   logic                 wr_en;

   always_comb begin
      leaf_n = {1'b1, cmd_ff.leaf};
      par_n = {1'b0, n_ff[NW-1:1]};
      leaf_e = (cmd_ff.op == REQ_INSERT) ? {{(EW-40){1'b0}}, cmd_ff.energy} : '0;
      leaf_v = (cmd_ff.op == REQ_INSERT) ? {cmd_ff.envelope[62], cmd_ff.envelope} : SENT;
      sib_e = rda_vld_ff ? rda_e_ff : '0;
      sib_v = rda_vld_ff ? rda_v_ff : SENT;
      rgt_v = rdb_vld_ff ? rdb_v_ff : SENT;
      // The node just written is one child of the parent, the sibling read is the other.
      if (n_ff[0]) begin
         l_e = sib_e;
         l_v = sib_v;
         r_e = cur_e_ff;
         r_v = cur_v_ff;
      end else begin
         l_e = cur_e_ff;
         l_v = cur_v_ff;
         r_e = sib_e;
         r_v = sib_v;
      end
      esum = {1'b0, l_e} + {1'b0, r_e};
      pe = esum[EW] ? E_MAX : esum[EW-1:0];
      asum = $signed({l_v[VW-1], l_v}) + $signed({{(VW+1-EW){1'b0}}, r_e});
      if (l_v == SENT) pa = SENT;
      else if (asum > $signed({1'b0, ENV_MAX})) pa = ENV_MAX;
      else pa = asum[VW-1:0];
      pv = (pa > r_v) ? pa : r_v;
      // Descent: port A holds the left child, port B the right child.
      if (dv_ff == rgt_v) begin
         nxt_n = {dn_ff[NW-2:0], 1'b1};
         nxt_v = rgt_v;
      end else begin
         nxt_n = {dn_ff[NW-2:0], 1'b0};
         nxt_v = sib_v;
      end
   end

   always_comb begin
      addr_a = {par_n[NW-1:1], ~par_n[0]};
      addr_b = NW'(3);
      wr_en = 1'b0;
      wr_addr = par_n;
      wr_e = pe;
      wr_v = pv;
      case (st_ff)
         S_LEAF: begin
            addr_a = {leaf_n[NW-1:1], ~leaf_n[0]};
            wr_en = 1'b1;
            wr_addr = leaf_n;
            wr_e = leaf_e;
            wr_v = leaf_v;
         end
         S_UP: begin
            wr_en = 1'b1;
            // At the root, fetch both children to start the descent.
            if (par_n == NW'(1)) addr_a = NW'(2);
         end
         S_DOWN: begin
            addr_a = {nxt_n[NW-2:0], 1'b0};
            addr_b = {nxt_n[NW-2:0], 1'b1};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         en_mem[wr_addr] <= wr_e;
         ev_mem[wr_addr] <= wr_v;
      end
      rda_e_ff <= en_mem[addr_a];
      rda_v_ff <= ev_mem[addr_a];
      rdb_v_ff <= ev_mem[addr_b];
      rda_vld_ff <= vld_ff[addr_a];
      rdb_vld_ff <= vld_ff[addr_b];
   end

   assign q_take = (st_ff == S_IDLE) && q_valid;
   assign rsp_valid = (st_ff == S_OUT);
   assign rsp_root_energy = root_e_ff;
   assign rsp_tree_empty = (root_v_ff == SENT);
   assign rsp_root_envelope = rsp_tree_empty ? {1'b1, 62'b0} : root_v_ff[62:0];
   assign rsp_leftmost_leaf = rsp_tree_empty ? 6'd0 : lf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         vld_ff <= '0;
         root_e_ff <= '0;
         root_v_ff <= SENT;
         lf_ff <= '0;
      end else begin
         unique case (st_ff)
            S_IDLE: if (q_valid) begin
               cmd_ff <= q_cmd;
               unique case (q_cmd.op)
                  REQ_CLEAR: begin
                     vld_ff <= '0;
                     root_e_ff <= '0;
                     root_v_ff <= SENT;
                     st_ff <= S_OUT;
                  end
                  // The tree is unchanged, so the last leftmost leaf still holds.
                  REQ_NONE: st_ff <= S_OUT;
                  default: st_ff <= S_LEAF;
               endcase
            end
            S_LEAF: begin
               vld_ff[leaf_n] <= 1'b1;
               n_ff <= leaf_n;
               cur_e_ff <= leaf_e;
               cur_v_ff <= leaf_v;
               st_ff <= S_UP;
            end
            S_UP: begin
               vld_ff[par_n] <= 1'b1;
               n_ff <= par_n;
               cur_e_ff <= pe;
               cur_v_ff <= pv;
               if (par_n == NW'(1)) begin
                  root_e_ff <= pe;
                  root_v_ff <= pv;
                  dn_ff <= NW'(1);
                  dv_ff <= pv;
                  st_ff <= S_DOWN;
               end
            end
            S_DOWN: begin
               dn_ff <= nxt_n;
               dv_ff <= nxt_v;
               if (nxt_n[NW-1]) begin
                  lf_ff <= 6'(nxt_n[NW-2:0]);
                  st_ff <= S_OUT;
               end
            end
            S_OUT: if (!rsp_stall) st_ff <= S_IDLE;
            default: st_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

/* rtl/theta_tree_energy_envelope.sv */
`default_nettype none
// Theta-tree over 64 leaves. Each request is queued by a two-entry front stage,
// then the back engine writes the leaf, climbs one level per cycle to the root
// (reading each sibling from node memory) and descends one level per cycle to
// find the leftmost leaf. An insert or remove passes through the states S_IDLE
// (take the item), S_LEAF (write the leaf), S_UP (one per level up), S_DOWN (one
// per level down) and S_OUT (present the result). A clear or an ignored request
// goes from S_IDLE straight to S_OUT. Clear resets per-node valid bits at once.
// One result per request, held while rsp_stall is high.
module theta_tree_energy_envelope import tte_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_type,
   input  wire logic [5:0]  req_leaf,
   input  wire logic [39:0] req_task_energy,
   input  wire logic [62:0] req_task_envelope,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [45:0]      rsp_root_energy,
   output logic [62:0]      rsp_root_envelope,
   output logic [5:0]       rsp_leftmost_leaf,
   output logic             rsp_tree_empty
);
   logic q_valid, q_take;
   cmd_type q_cmd;
   tte_front u_front (.clock, .reset, .req_valid, .req_stall, .req_type, .req_leaf,
      .req_task_energy, .req_task_envelope, .q_valid, .q_cmd, .q_take);
   tte_back u_back (.clock, .reset, .q_valid, .q_cmd, .q_take, .rsp_valid, .rsp_stall,
      .rsp_root_energy, .rsp_root_envelope, .rsp_leftmost_leaf, .rsp_tree_empty);
endmodule
`default_nettype wire

/* rtl/tte_checker.sv */
`default_nettype none
module tte_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [62:0] rsp_root_envelope,
   input wire logic [5:0]  rsp_leftmost_leaf,
   input wire logic        rsp_tree_empty
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_root_envelope))
      else $error("rsp changed while stalled");
   a_empty_leaf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_tree_empty |-> rsp_leftmost_leaf == 6'd0)
      else $error("empty tree with nonzero leaf");
   a_empty_env: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_tree_empty |-> rsp_root_envelope == {1'b1, 62'd0})
      else $error("empty tree envelope not minimum");
   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp valid after reset");
endmodule
bind theta_tree_energy_envelope tte_checker u_chk (.clock, .reset, .rsp_valid,
   .rsp_stall, .rsp_root_envelope, .rsp_leftmost_leaf, .rsp_tree_empty);
`default_nettype wire

/* test/tb_theta_tree_energy_envelope.sv */
`timescale 1ns / 100ps
module tb_theta_tree_energy_envelope;
   import tte_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int RANDOM_ITEMS = 1750;

   typedef struct packed {
      logic [45:0] energy;
      logic [62:0] envelope;
      logic [5:0]  leaf;
      logic        empty;
   } root_view;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_type = REQ_NONE;
   logic [5:0]  req_leaf = '0;
   logic [39:0] req_task_energy = '0;
   logic [62:0] req_task_envelope = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [45:0] rsp_root_energy;
   logic [62:0] rsp_root_envelope;
   logic [5:0]  rsp_leftmost_leaf;
   logic        rsp_tree_empty;

   logic [EW-1:0]        tree_energy [2*PAD];
   logic signed [VW-1:0] tree_env [2*PAD];
   root_view             expected_roots [$];

   int  mismatches = 0;
   int  cycles = 0;
   bit  idling_on = 1'b1;
   bit  hold_results = 1'b0;
   int  stall_left = 0;

   theta_tree_energy_envelope dut (
      .clock, .reset, .req_valid, .req_stall, .req_type, .req_leaf,
      .req_task_energy, .req_task_envelope, .rsp_valid, .rsp_stall,
      .rsp_root_energy, .rsp_root_envelope, .rsp_leftmost_leaf, .rsp_tree_empty
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic void clear_tree();
      for (int i = 0; i < 2*PAD; i++) begin
         tree_energy[i] = '0;
         tree_env[i] = SENT;
      end
   endfunction

   // Updates a leaf-to-root path (or clears all) and returns the root's view.
   function automatic root_view tree_apply(op_type op, logic [5:0] lf, logic [39:0] e,
                                           logic [62:0] env);
      int n;
      logic [EW:0] sum;
      logic signed [VW-1:0] a;
      root_view rv;
      if (op == REQ_CLEAR) begin
         clear_tree();
      end else if ((op == REQ_INSERT || op == REQ_REMOVE) && lf < LEAVES) begin
         n = PAD + lf;
         tree_energy[n] = (op == REQ_INSERT) ? EW'(e) : '0;
         tree_env[n] = (op == REQ_INSERT) ? {env[62], env} : SENT;
         n = n >> 1;
         while (n != 0) begin
            sum = tree_energy[2*n] + tree_energy[2*n+1];
            tree_energy[n] = (sum > E_MAX) ? E_MAX : sum[EW-1:0];
            if (tree_env[2*n] == SENT) begin
               a = SENT;
            end else begin
               a = tree_env[2*n] + $signed({18'b0, tree_energy[2*n+1]});
               if (a > ENV_MAX) a = ENV_MAX;
            end
            tree_env[n] = (a > tree_env[2*n+1]) ? a : tree_env[2*n+1];
            n = n >> 1;
         end
      end
      rv.energy = tree_energy[1];
      rv.empty = (tree_env[1] == SENT);
      if (rv.empty) begin
         rv.envelope = {1'b1, 62'b0};
         rv.leaf = '0;
      end else begin
         rv.envelope = tree_env[1][62:0];
         // Descend toward the node that sets the envelope; ties go right.
         n = 1;
         while (n < PAD) n = (tree_env[n] == tree_env[2*n+1]) ? 2*n+1 : 2*n;
         rv.leaf = 6'(n - PAD);
      end
      return rv;
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_request(op_type op, logic [5:0] lf, logic [39:0] e,
                               logic [62:0] env);
      int gap;
      root_view rv;
      gap = (idling_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 19) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_type <= op;
      req_leaf <= lf;
      req_task_energy <= e;
      req_task_envelope <= env;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      rv = tree_apply(op, lf, e, env);
      expected_roots.insert(expected_roots.size(), rv);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      wait (expected_roots.size() == 0);
      repeat (20) @(negedge clock);
   endtask

   function automatic logic [39:0] pick_energy();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2: return 40'($urandom_range(0, 20));
         default: return 40'({$urandom, $urandom});
      endcase
   endfunction

   function automatic logic [62:0] pick_envelope();
      case ($urandom_range(0, 7))
         0: return {1'b0, {62{1'b1}}};
         1: return {1'b1, 62'b0};
         2: return 63'($urandom_range(0, 40));
         3: return -63'($urandom_range(0, 40));
         4: return {31'b0, $urandom};
         default: return 63'({$urandom, $urandom});
      endcase
   endfunction

   task automatic random_request(bit narrow);
      op_type op;
      int r;
      logic [5:0] lf;
      r = $urandom_range(0, 99);
      op = (r < 60) ? REQ_INSERT : (r < 92) ? REQ_REMOVE : (r < 95) ? REQ_CLEAR : REQ_NONE;
      // Narrow items crowd a few leaves with small values so ties are common.
      lf = narrow ? 6'($urandom_range(0, 7)) : 6'($urandom);
      if (narrow)
         send_request(op, lf, 40'($urandom_range(0, 3)), 63'($urandom_range(0, 6)));
      else
         send_request(op, lf, pick_energy(), pick_envelope());
   endtask

   task automatic test_directed();
      send_request(REQ_REMOVE, 6'd3, '0, '0);
      send_request(REQ_CLEAR, 6'd0, '0, '0);
      send_request(REQ_INSERT, 6'd0, '1, {1'b0, {62{1'b1}}});
      send_request(REQ_INSERT, 6'd63, '1, {1'b1, 62'b0});
      send_request(REQ_INSERT, 6'd32, '1, 63'd5);
      send_request(REQ_INSERT, 6'd32, 40'd7, 63'd9);
      send_request(REQ_NONE, 6'd17, '1, '1);
      send_request(REQ_REMOVE, 6'd0, '0, '0);
      send_request(REQ_REMOVE, 6'd63, '0, '0);
      send_request(REQ_REMOVE, 6'd32, '0, '0);
      send_request(REQ_INSERT, 6'd5, '0, 63'd100);
      send_request(REQ_INSERT, 6'd9, '0, 63'd100);
      send_request(REQ_INSERT, 6'd2, 40'd3, -63'd4);
      send_request(REQ_INSERT, 6'd40, '0, -63'd1);
      send_request(REQ_INSERT, 6'd1, 40'd50, {1'b0, {62{1'b1}}} - 63'd10);
      send_request(REQ_INSERT, 6'd62, '1, 63'd0);
      send_request(REQ_REMOVE, 6'd1, '1, '1);
      send_request(REQ_CLEAR, 6'd21, '1, '1);
      send_request(REQ_INSERT, 6'd0, '0, {1'b1, 62'b0});
      send_request(REQ_CLEAR, 6'd0, '0, '0);
      wait_drained();
   endtask

   task automatic test_backpressure();
      fork
         begin
            hold_results = 1'b1;
            repeat (300) @(negedge clock);
            hold_results = 1'b0;
         end
         repeat (40) random_request(1'b0);
      join
      wait_drained();
   endtask

   task automatic test_random();
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS - 300) idling_on = 1'b0;
         random_request($urandom_range(0, 2) == 0);
      end
      req_valid <= 1'b0;
   endtask

   // Receiver side: random stall bursts, a long hold on request, none at the end.
   always @(negedge clock) begin
      if (hold_results) begin
         rsp_stall <= 1'b1;
      end else if (!idling_on) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(0, 2) == 0);
         stall_left <= $urandom_range(1, 19);
      end
   end

   always @(posedge clock) begin
      root_view got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_root_energy, rsp_root_envelope, rsp_leftmost_leaf, rsp_tree_empty};
         if (expected_roots.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result at cycle %0d", cycles);
         end else begin
            want = expected_roots.pop_front();
            if (got.energy !== want.energy || got.envelope !== want.envelope ||
                got.leaf !== want.leaf || got.empty !== want.empty) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: energy %h/%h envelope %h/%h leaf %0d/%0d empty %b/%b",
                           want.energy, got.energy, want.envelope, got.envelope,
                           want.leaf, got.leaf, want.empty, got.empty);
            end
         end
      end
   end

   initial begin
      clear_tree();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_backpressure();
      test_random();
      wait (expected_roots.size() == 0);
      repeat (40) @(posedge clock);
      if (mismatches == 0 && expected_roots.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
